/* rtl/core/channel_volume_balance_gain_unit_assert.svh */
// Assertion macros shared by the checker of the channel gain unit.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef CHANNEL_VOLUME_BALANCE_GAIN_UNIT_ASSERT_SVH
`define CHANNEL_VOLUME_BALANCE_GAIN_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cvb_checker: implication violated");

// The expression must never be true outside reset.
`define CVB_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("cvb_checker: forbidden condition seen");

`endif

/* rtl/core/cvb_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, command codes, the pipeline tag type and the Q28 power table
// of the channel gain unit. No dependencies.
package cvb_pkg;

    localparam int NUM_CHANNELS_DEF = 40;

    localparam int CH_W   = 6;
    localparam int VOL_W  = 12;
    localparam int BAL_W  = 7;
    localparam int GAIN_W = 8;
    localparam int WGT_W  = 7;
    localparam int M_W    = 32;
    localparam int ROM_W  = 31;
    localparam int Q_W    = 3;
    localparam int R_W    = 9;

    localparam logic CMD_VOLUME  = 1'b0;
    localparam logic CMD_BALANCE = 1'b1;

    localparam logic [BAL_W-1:0] BAL_MAX = 7'd100;

    typedef struct packed {
        logic            vld;
        logic [CH_W-1:0] ch;
    } t_tag;

    // Q28 value of 10^(2^k/320).
    function automatic logic [30:0] pow_q28(input int k);
        logic [30:0] p;
        case (k)
            0:       p = 31'd270373970;
            1:       p = 31'd272326484;
            2:       p = 31'd276273913;
            3:       p = 31'd284341257;
            4:       p = 31'd301189535;
            5:       p = 31'd337940217;
            6:       p = 31'd425441527;
            7:       p = 31'd674279380;
            8:       p = 31'd1693713225;
            default: p = 31'd0;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/channel_volume_balance_gain_unit.sv */
`timescale 1ns / 1ps
// Top level of the per-channel volume and balance to stereo gain unit.
// Depends on cvb_pkg, cvb_store, cvb_lin and cvb_gain.
//
// Usage: a host drives one command beat (set volume or set balance for a
// mixer channel) with start; the beat is taken at a rising edge where start
// is high and busy is low. busy is high only while reset is held, so a beat
// can be taken on every clock cycle. The command updates the channel store,
// and both stored values of that channel give a left and a right 8-bit gain.
// Each result beat is shown for one cycle with o_valid high and is taken at
// the edge that ends that cycle; the receiver cannot stall it.
// The throughput is one command per cycle, set by the fully pipelined
// datapath (store read, nine Q28 product stages, scaling and weighting).
// A command for a channel at or above NUM_CHANNELS gives no result.
// Reset clears all channels to 0 dB and balance 0 at once, and drops every
// beat still in flight.
module channel_volume_balance_gain_unit import cvb_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_command,
    input  logic [CH_W-1:0]         i_channel,
    input  logic signed [VOL_W-1:0] i_volume_db,
    input  logic [BAL_W-1:0]        i_balance,
    output logic                    o_valid,
    output logic [CH_W-1:0]         o_out_channel,
    output logic [GAIN_W-1:0]       o_gain_left,
    output logic [GAIN_W-1:0]       o_gain_right
);

    logic                    accept;
    t_tag                    st_tag;
    logic signed [VOL_W-1:0] st_volume;
    logic [BAL_W-1:0]        st_balance;
    t_tag                    ln_tag;
    logic [ROM_W-1:0]        ln_rom;
    logic [WGT_W-1:0]        ln_wl;
    logic [WGT_W-1:0]        ln_wr;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    cvb_store #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_channel   (i_channel),
        .i_volume_db (i_volume_db),
        .i_balance   (i_balance),
        .o_tag       (st_tag),
        .o_volume    (st_volume),
        .o_balance   (st_balance)
    );

    cvb_lin u_lin (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tag          (st_tag),
        .i_volume       (st_volume),
        .i_balance      (st_balance),
        .o_tag          (ln_tag),
        .o_rom          (ln_rom),
        .o_weight_left  (ln_wl),
        .o_weight_right (ln_wr)
    );

    cvb_gain u_gain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tag          (ln_tag),
        .i_rom          (ln_rom),
        .i_weight_left  (ln_wl),
        .i_weight_right (ln_wr),
        .o_valid        (o_valid),
        .o_out_channel  (o_out_channel),
        .o_gain_left    (o_gain_left),
        .o_gain_right   (o_gain_right)
    );

endmodule

/* rtl/core/cvb_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cvb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cvb_store.sv */
`timescale 1ns / 1ps
// Per-channel volume and balance store with reset valid bits and the input
// register stage. Depends on cvb_pkg and cvb_ram.
module cvb_store import cvb_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic                    i_command,
    input  logic [CH_W-1:0]         i_channel,
    input  logic signed [VOL_W-1:0] i_volume_db,
    input  logic [BAL_W-1:0]        i_balance,
    output t_tag                    o_tag,
    output logic signed [VOL_W-1:0] o_volume,
    output logic [BAL_W-1:0]        o_balance
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                    in_range;
    logic                    wr_vol;
    logic                    wr_bal;
    logic [AW-1:0]           addr;
    logic [BAL_W-1:0]        bal_clamp;
    logic [VOL_W-1:0]        vol_rd;
    logic [BAL_W-1:0]        bal_rd;

    logic [NUM_CHANNELS-1:0] r_vol_set;
    logic [NUM_CHANNELS-1:0] r_bal_set;
    logic                    r_vol_ok;
    logic                    r_bal_ok;
    logic                    r_vld;
    logic [CH_W-1:0]         r_ch;
    logic                    r_cmd;
    logic signed [VOL_W-1:0] r_vol;
    logic [BAL_W-1:0]        r_bal;

    assign in_range  = {1'b0, i_channel} < (CH_W + 1)'(NUM_CHANNELS);
    assign addr      = i_channel[AW-1:0];
    assign bal_clamp = (i_balance > BAL_MAX) ? BAL_MAX : i_balance;
    assign wr_vol    = i_accept && in_range && (i_command == CMD_VOLUME);
    assign wr_bal    = i_accept && in_range && (i_command == CMD_BALANCE);

    cvb_ram #(
        .WIDTH (VOL_W),
        .DEPTH (NUM_CHANNELS)
    ) u_vol_ram (
        .i_clk   (i_clk),
        .i_we    (wr_vol),
        .i_waddr (addr),
        .i_wdata (unsigned'(i_volume_db)),
        .i_raddr (addr),
        .o_rdata (vol_rd)
    );

    cvb_ram #(
        .WIDTH (BAL_W),
        .DEPTH (NUM_CHANNELS)
    ) u_bal_ram (
        .i_clk   (i_clk),
        .i_we    (wr_bal),
        .i_waddr (addr),
        .i_wdata (bal_clamp),
        .i_raddr (addr),
        .o_rdata (bal_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_set <= '0;
            r_bal_set <= '0;
            r_vld     <= 1'b0;
        end else begin
            if (wr_vol) begin
                r_vol_set[addr] <= 1'b1;
            end
            if (wr_bal) begin
                r_bal_set[addr] <= 1'b1;
            end
            r_vld <= i_accept && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vol_ok <= r_vol_set[addr];
        r_bal_ok <= r_bal_set[addr];
        r_ch     <= i_channel;
        r_cmd    <= i_command;
        r_vol    <= i_volume_db;
        r_bal    <= bal_clamp;
    end

    // A channel never written since reset reads as 0 dB and full left.
    assign o_tag     = '{vld: r_vld, ch: r_ch};
    assign o_volume  = (r_cmd == CMD_VOLUME) ? r_vol :
                       (r_vol_ok ? signed'(vol_rd) : '0);
    assign o_balance = (r_cmd == CMD_BALANCE) ? r_bal :
                       (r_bal_ok ? bal_rd : '0);

endmodule

/* rtl/core/cvb_lin.sv */
`timescale 1ns / 1ps
// Pipeline from volume to linear factor: clamp and split, nine Q28 product
// stages, scaling by a multiply or a corrected reciprocal. Depends on cvb_pkg.
module cvb_lin import cvb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tag                    i_tag,
    input  logic signed [VOL_W-1:0] i_volume,
    input  logic [BAL_W-1:0]        i_balance,
    output t_tag                    o_tag,
    output logic [ROM_W-1:0]        o_rom,
    output logic [WGT_W-1:0]        o_weight_left,
    output logic [WGT_W-1:0]        o_weight_right
);

    localparam int STAGES = R_W;
    localparam int T_W    = 11;
    localparam int A_W    = 26;
    localparam int RD_W   = 30;
    localparam int QT_W   = 24;
    localparam int D_W    = 7;
    localparam int BIG_W  = 39;
    localparam int HI_W   = BIG_W - 5;

    localparam logic signed [VOL_W-1:0] V_MIN  = -12'sd960;
    localparam logic signed [VOL_W-1:0] V_MAX  = 12'sd959;
    localparam logic signed [VOL_W-1:0] V_OFFS = 12'sd960;
    localparam logic [M_W-1:0]          M_ONE  = 32'h1000_0000;
    localparam logic [2*M_W-1:0]        HALF   = 64'h0000_0000_0800_0000;

    localparam logic [RD_W-1:0] RD_125 = 30'd34359738;
    localparam logic [RD_W-1:0] RD_25  = 30'd171798691;
    localparam logic [RD_W-1:0] RD_5   = 30'd858993459;

    logic signed [VOL_W-1:0] vc;
    logic signed [VOL_W-1:0] vsum;
    logic [T_W-1:0]          t;
    logic [Q_W-1:0]          q;
    logic [R_W-1:0]          r;
    logic [WGT_W-1:0]        wl;
    logic [WGT_W-1:0]        wr;

    logic [STAGES:0]   r_vld;
    logic [CH_W-1:0]   r_ch [0:STAGES];
    logic [M_W-1:0]    r_m  [0:STAGES];
    logic [R_W-1:0]    r_r  [0:STAGES];
    logic [Q_W-1:0]    r_q  [0:STAGES];
    logic [WGT_W-1:0]  r_wl [0:STAGES];
    logic [WGT_W-1:0]  r_wr [0:STAGES];
    logic [M_W-1:0]    n_m  [0:STAGES-1];

    logic [M_W-1:0]    m_fin;
    logic [Q_W-1:0]    q_fin;
    logic [D_W-1:0]    num;
    logic [BIG_W-1:0]  big;
    logic [HI_W-1:0]   hi;
    logic [ROM_W-1:0]  hi_cap;
    logic [A_W-1:0]    a;
    logic [RD_W-1:0]   rd;
    logic [D_W-1:0]    d;
    logic [A_W+RD_W-1:0] qe;

    logic              r_dvld;
    logic [CH_W-1:0]   r_dch;
    logic [WGT_W-1:0]  r_dwl;
    logic [WGT_W-1:0]  r_dwr;
    logic              r_ddirect;
    logic [ROM_W-1:0]  r_dhi;
    logic [A_W-1:0]    r_da;
    logic [QT_W-1:0]   r_dq0;
    logic [D_W-1:0]    r_dd;

    logic [QT_W+D_W-1:0] back;
    logic [A_W-1:0]      rem;
    logic [QT_W-1:0]     quot;

    logic              r_evld;
    logic [CH_W-1:0]   r_ech;
    logic [WGT_W-1:0]  r_ewl;
    logic [WGT_W-1:0]  r_ewr;
    logic [ROM_W-1:0]  r_rom;

    always_comb begin
        vc = i_volume;
        if (i_volume < V_MIN) begin
            vc = V_MIN;
        end else if (i_volume > V_MAX) begin
            vc = V_MAX;
        end
        vsum = vc + V_OFFS;
        t    = vsum[T_W-1:0];
        if (t >= 11'd1600) begin
            q = 3'd5;
            r = R_W'(t - 11'd1600);
        end else if (t >= 11'd1280) begin
            q = 3'd4;
            r = R_W'(t - 11'd1280);
        end else if (t >= 11'd960) begin
            q = 3'd3;
            r = R_W'(t - 11'd960);
        end else if (t >= 11'd640) begin
            q = 3'd2;
            r = R_W'(t - 11'd640);
        end else if (t >= 11'd320) begin
            q = 3'd1;
            r = R_W'(t - 11'd320);
        end else begin
            q = 3'd0;
            r = t[R_W-1:0];
        end

        if (i_balance <= 7'd50) begin
            wl = 7'd100;
        end else begin
            wl = WGT_W'(8'd200 - {i_balance, 1'b0});
        end
        if (i_balance >= 7'd50) begin
            wr = 7'd100;
        end else begin
            wr = WGT_W'({i_balance, 1'b0});
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_step
        logic [2*M_W-1:0] prod;
        logic [2*M_W-1:0] rnd;
        assign prod   = r_m[g] * {1'b0, pow_q28(g)};
        assign rnd    = prod + HALF;
        assign n_m[g] = r_r[g][g] ? rnd[M_W+27:28] : r_m[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_dvld <= 1'b0;
            r_evld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[STAGES-1:0], i_tag.vld};
            r_dvld <= r_vld[STAGES];
            r_evld <= r_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch[0] <= i_tag.ch;
        r_m[0]  <= M_ONE;
        r_r[0]  <= r;
        r_q[0]  <= q;
        r_wl[0] <= wl;
        r_wr[0] <= wr;
        for (int k = 1; k <= STAGES; k++) begin
            r_ch[k] <= r_ch[k-1];
            r_m[k]  <= n_m[k-1];
            r_r[k]  <= r_r[k-1];
            r_q[k]  <= r_q[k-1];
            r_wl[k] <= r_wl[k-1];
            r_wr[k] <= r_wr[k-1];
        end
    end

    // The three lowest decades divide by 32000, 3200 and 320, taken as a
    // shift followed by a division by 125, 25 or 5.
    always_comb begin
        m_fin = r_m[STAGES];
        q_fin = r_q[STAGES];
        unique case (q_fin)
            3'd4:    num = 7'd10;
            3'd5:    num = 7'd100;
            default: num = 7'd1;
        endcase
        big    = BIG_W'(m_fin) * BIG_W'(num);
        hi     = big[BIG_W-1:5];
        hi_cap = (|hi[HI_W-1:ROM_W]) ? '1 : hi[ROM_W-1:0];
        unique case (q_fin)
            3'd0: begin
                a  = A_W'(m_fin >> 8);
                rd = RD_125;
                d  = 7'd125;
            end
            3'd1: begin
                a  = A_W'(m_fin >> 7);
                rd = RD_25;
                d  = 7'd25;
            end
            default: begin
                a  = A_W'(m_fin >> 6);
                rd = RD_5;
                d  = 7'd5;
            end
        endcase
        qe = (A_W + RD_W)'(a) * (A_W + RD_W)'(rd);
    end

    always_ff @(posedge i_clk) begin
        r_dch     <= r_ch[STAGES];
        r_dwl     <= r_wl[STAGES];
        r_dwr     <= r_wr[STAGES];
        r_ddirect <= (q_fin >= 3'd3);
        r_dhi     <= hi_cap;
        r_da      <= a;
        r_dq0     <= qe[A_W+RD_W-1-(A_W+RD_W-32-QT_W) -: QT_W];
        r_dd      <= d;
    end

    always_comb begin
        back = (QT_W + D_W)'(r_dq0) * (QT_W + D_W)'(r_dd);
        rem  = r_da - back[A_W-1:0];
        quot = (rem >= A_W'(r_dd)) ? (r_dq0 + QT_W'(1)) : r_dq0;
    end

    always_ff @(posedge i_clk) begin
        r_ech <= r_dch;
        r_ewl <= r_dwl;
        r_ewr <= r_dwr;
        r_rom <= r_ddirect ? r_dhi : ROM_W'(quot);
    end

    assign o_tag          = '{vld: r_evld, ch: r_ech};
    assign o_rom          = r_rom;
    assign o_weight_left  = r_ewl;
    assign o_weight_right = r_ewr;

endmodule

/* rtl/core/cvb_gain.sv */
`timescale 1ns / 1ps
// Weighting of the linear factor into the two 8-bit channel gains with
// saturation, and the result register. Depends on cvb_pkg.
module cvb_gain import cvb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  logic [ROM_W-1:0]  i_rom,
    input  logic [WGT_W-1:0]  i_weight_left,
    input  logic [WGT_W-1:0]  i_weight_right,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_out_channel,
    output logic [GAIN_W-1:0] o_gain_left,
    output logic [GAIN_W-1:0] o_gain_right
);

    localparam int Y_W   = ROM_W + WGT_W;
    localparam int Z_W   = Y_W - 18;
    localparam int ZS_W  = 13;
    localparam int RC_W  = 16;
    localparam int P_W   = ZS_W + RC_W;

    // The gain divisor is 2^18 * 25; one step shifts, the other multiplies by
    // a reciprocal that is exact below the saturation limit.
    localparam logic [Z_W-1:0]  SAT_LIMIT = 20'd6400;
    localparam logic [RC_W-1:0] RECIP_25  = 16'd41944;

    logic [Y_W-1:0]    yl;
    logic [Y_W-1:0]    yr;
    logic [P_W-1:0]    pl;
    logic [P_W-1:0]    pr;
    logic [GAIN_W-1:0] n_gl;
    logic [GAIN_W-1:0] n_gr;

    logic              r_gvld;
    logic [CH_W-1:0]   r_gch;
    logic [Z_W-1:0]    r_zl;
    logic [Z_W-1:0]    r_zr;
    logic              r_ovld;
    logic [CH_W-1:0]   r_och;
    logic [GAIN_W-1:0] r_gl;
    logic [GAIN_W-1:0] r_gr;

    assign yl = Y_W'(i_rom) * Y_W'(i_weight_left);
    assign yr = Y_W'(i_rom) * Y_W'(i_weight_right);

    always_comb begin
        pl   = P_W'(r_zl[ZS_W-1:0]) * P_W'(RECIP_25);
        pr   = P_W'(r_zr[ZS_W-1:0]) * P_W'(RECIP_25);
        n_gl = (r_zl >= SAT_LIMIT) ? '1 : pl[27:20];
        n_gr = (r_zr >= SAT_LIMIT) ? '1 : pr[27:20];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvld <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_gvld <= i_tag.vld;
            r_ovld <= r_gvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gch <= i_tag.ch;
        r_zl  <= yl[Y_W-1:18];
        r_zr  <= yr[Y_W-1:18];
        r_och <= r_gch;
        r_gl  <= n_gl;
        r_gr  <= n_gr;
    end

    assign o_valid       = r_ovld;
    assign o_out_channel = r_och;
    assign o_gain_left   = r_gl;
    assign o_gain_right  = r_gr;

endmodule

/* rtl/core/cvb_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the channel gain unit and its bind to the top level.
// Depends on cvb_pkg and channel_volume_balance_gain_unit_assert.svh.
`include "channel_volume_balance_gain_unit_assert.svh"

module cvb_checker import cvb_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    i_command,
    input logic [CH_W-1:0]         i_channel,
    input logic [BAL_W-1:0]        i_balance,
    input logic                    o_valid,
    input logic [CH_W-1:0]         o_out_channel,
    input logic [GAIN_W-1:0]       o_gain_left,
    input logic [GAIN_W-1:0]       o_gain_right
);

    localparam int LAT = 15;

    logic accepted;
    logic full_left_cmd;
    logic full_right_cmd;
    logic out_ch_bad;

    assign accepted       = start && !busy;
    assign full_left_cmd  = (i_command == CMD_BALANCE) && (i_balance == 7'd0);
    assign full_right_cmd = (i_command == CMD_BALANCE) && (i_balance >= BAL_MAX);
    assign out_ch_bad     = {1'b0, o_out_channel} >= (CH_W + 1)'(NUM_CHANNELS);

    `CVB_ASSERT_IMPLY(a_result_has_command, o_valid, $past(accepted, LAT))
    `CVB_ASSERT_IMPLY(a_result_channel, o_valid, o_out_channel == $past(i_channel, LAT))
    `CVB_ASSERT_NEVER(a_channel_range, o_valid && out_ch_bad)
    `CVB_ASSERT_IMPLY(a_full_left_mutes_right, o_valid && $past(full_left_cmd, LAT), o_gain_right == 8'd0)
    `CVB_ASSERT_IMPLY(a_full_right_mutes_left, o_valid && $past(full_right_cmd, LAT), o_gain_left == 8'd0)

endmodule

bind channel_volume_balance_gain_unit cvb_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_cvb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_command     (i_command),
    .i_channel     (i_channel),
    .i_balance     (i_balance),
    .o_valid       (o_valid),
    .o_out_channel (o_out_channel),
    .o_gain_left   (o_gain_left),
    .o_gain_right  (o_gain_right)
);
